>>> design/fcub_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcub_pkg;

	localparam int UID_FIELD_W = 32;
	localparam int UID_WIDTH_DEF = 32;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [MODE_W-1:0] MODE_DELETED = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FLAGGED = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OLD     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REPLIED = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TAGGED  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_TRASH   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGED_ONLY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SENSE = 2'd2;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_FIRST = 2'd1;
	localparam logic [1:0] KIND_COMMA = 2'd2;
	localparam logic [1:0] KIND_COLON = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] flag_mode;
		logic              changed_only;
		logic              invert_sense;
	} cfg_t;

	typedef struct packed {
		logic                   active;
		logic [4:0]             local_flags;
		logic [4:0]             server_flags;
		logic                   tagged_req;
		logic                   purge;
		logic                   changed_mark;
		logic [UID_FIELD_W-1:0] uid;
		logic                   is_last;
	} rec_t;

	typedef struct packed {
		logic [1:0]             token_kind;
		logic [UID_FIELD_W-1:0] token_uid;
		logic [COUNT_W-1:0]     match_count;
		logic                   set_done;
	} res_t;

endpackage

`default_nettype wire

>>> design/fcub_select.sv
`timescale 1ns / 1ps
`default_nettype none

module fcub_select
	import fcub_pkg::*;
(
	input  wire cfg_t cfg,
	input  wire rec_t rec,
	output logic      sel
);

	logic lb;
	logic sb;
	logic hit;

	always_comb begin
		lb = 1'b0;
		sb = 1'b0;
		hit = 1'b0;
		case (cfg.flag_mode)
			MODE_DELETED: begin
				lb = rec.local_flags[0];
				sb = rec.server_flags[0];
				hit = (lb != sb) && (lb ^ cfg.invert_sense);
			end
			MODE_FLAGGED: begin
				lb = rec.local_flags[1];
				sb = rec.server_flags[1];
				hit = (lb != sb) && (lb ^ cfg.invert_sense);
			end
			MODE_OLD: begin
				lb = rec.local_flags[2];
				sb = rec.server_flags[2];
				hit = (lb != sb) && (lb ^ cfg.invert_sense);
			end
			MODE_READ: begin
				lb = rec.local_flags[3];
				sb = rec.server_flags[3];
				hit = (lb != sb) && (lb ^ cfg.invert_sense);
			end
			MODE_REPLIED: begin
				lb = rec.local_flags[4];
				sb = rec.server_flags[4];
				hit = (lb != sb) && (lb ^ cfg.invert_sense);
			end
			MODE_TAGGED: begin
				hit = rec.tagged_req;
			end
			MODE_TRASH: begin
				hit = rec.local_flags[0] && !rec.purge;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		sel = rec.active && hit && (!cfg.changed_only || rec.changed_mark);
	end

endmodule

`default_nettype wire

>>> design/fcub_run.sv
`timescale 1ns / 1ps
`default_nettype none

module fcub_run
	import fcub_pkg::*;
#(
	parameter int UID_WIDTH = UID_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        take,
	input  wire rec_t  rec,
	input  wire        sel,
	output res_t       res
);

	localparam int UW = (UID_WIDTH < UID_FIELD_W) ? UID_WIDTH : UID_FIELD_W;

	logic               run_open_q;
	logic [UW-1:0]      run_start_q;
	logic [UW-1:0]      prev_q;
	logic               any_q;
	logic [COUNT_W-1:0] count_q;

	logic [UW-1:0]      uid;
	logic [COUNT_W-1:0] count_d;
	logic               run_open_d;
	logic [UW-1:0]      run_start_d;
	logic               any_d;
	logic [1:0]         kind;
	logic [UW-1:0]      tok;

	assign uid = rec.uid[UW-1:0];

	always_comb begin
		count_d = count_q;
		run_open_d = run_open_q;
		run_start_d = run_start_q;
		any_d = any_q;
		kind = KIND_NONE;
		tok = '0;
		if (sel) begin
			if (count_q != COUNT_MAX) begin
				count_d = count_q + 1'b1;
			end
			if (!run_open_q) begin
				run_open_d = 1'b1;
				run_start_d = uid;
				kind = any_q ? KIND_COMMA : KIND_FIRST;
				tok = uid;
				any_d = 1'b1;
			end else if (rec.is_last) begin
				kind = KIND_COLON;
				tok = uid;
			end
		end else if (run_open_q && (rec.active || rec.is_last)) begin
			if (prev_q > run_start_q) begin
				kind = KIND_COLON;
				tok = prev_q;
			end
			run_open_d = 1'b0;
		end
	end

	assign res.token_kind = kind;
	assign res.token_uid = UID_FIELD_W'(tok);
	assign res.match_count = count_d;
	assign res.set_done = rec.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			run_start_q <= '0;
			prev_q <= '0;
			any_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			if (rec.is_last) begin
				run_open_q <= 1'b0;
				run_start_q <= '0;
				prev_q <= '0;
				any_q <= 1'b0;
				count_q <= '0;
			end else begin
				run_open_q <= run_open_d;
				run_start_q <= run_start_d;
				prev_q <= uid;
				any_q <= any_d;
				count_q <= count_d;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && rec.is_last |=> !run_open_q && !any_q && count_q == '0)
		else $error("state not cleared after last request");

	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.token_kind == KIND_FIRST |-> !any_q && !run_open_q)
		else $error("first token with set already started");

	a_open_on_sel: assert property (@(posedge clk) disable iff (!arst_n)
		take && sel && !rec.is_last |=> run_open_q && any_q && count_q != '0)
		else $error("selected request did not open run");

endmodule

`default_nettype wire

>>> design/fcub_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module fcub_outbuf
	import fcub_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	input  wire res_t push_res,
	output logic      full,
	output logic      out_valid,
	input  wire       out_stall,
	output res_t      out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic drain;

	assign drain = !out_valid_q || !out_stall;
	assign full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_res;
			end
		end
		if (push && !drain) begin
			skid_q <= push_res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds request with empty output");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("request pushed into full buffer");

	a_skid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> out_valid_q && !skid_valid_q)
		else $error("skid request not moved forward");

endmodule

`default_nettype wire

>>> design/flag_change_uid_set_builder.sv
// an accepted request's result is registered in the output register, or in the skid register while the output stalls
// throughput: one request per cycle while in_stall is low; the run state updates on every accepted request
// a two-entry output buffer lets requests flow while one result waits
// reset: asynchronous, clears config registers, run state and output buffer
`timescale 1ns / 1ps
`default_nettype none

module flag_change_uid_set_builder
	import fcub_pkg::*;
#(
	parameter int UID_WIDTH = UID_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [CFG_IDX_W-1:0]          cfg_index,
	input  wire [CFG_DATA_W-1:0]         cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          active,
	input  wire [4:0]                    local_flags,
	input  wire [4:0]                    server_flags,
	input  wire                          tagged_req,
	input  wire                          purge,
	input  wire                          changed_mark,
	input  wire [UID_FIELD_W-1:0]        uid,
	input  wire                          is_last,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   token_kind,
	output logic [UID_FIELD_W-1:0]       token_uid,
	output logic [COUNT_W-1:0]           match_count,
	output logic                         set_done
);

	cfg_t cfg_q;
	rec_t rec;
	res_t res;
	res_t out_res;
	logic sel;
	logic take;
	logic full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLAG_MODE:    cfg_q.flag_mode <= cfg_wdata[MODE_W-1:0];
				CFG_CHANGED_ONLY: cfg_q.changed_only <= cfg_wdata[0];
				CFG_INVERT_SENSE: cfg_q.invert_sense <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign rec.active = active;
	assign rec.local_flags = local_flags;
	assign rec.server_flags = server_flags;
	assign rec.tagged_req = tagged_req;
	assign rec.purge = purge;
	assign rec.changed_mark = changed_mark;
	assign rec.uid = uid;
	assign rec.is_last = is_last;

	assign in_stall = full;
	assign take = in_valid && !full;

	fcub_select u_select (
		.cfg (cfg_q),
		.rec (rec),
		.sel (sel)
	);

	fcub_run #(
		.UID_WIDTH (UID_WIDTH)
	) u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.rec    (rec),
		.sel    (sel),
		.res    (res)
	);

	fcub_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_res  (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign token_kind = out_res.token_kind;
	assign token_uid = out_res.token_uid;
	assign match_count = out_res.match_count;
	assign set_done = out_res.set_done;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fcub_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	class uid_set_scoreboard;
		cfg_t                   cfg;
		bit                     run_open;
		bit [UID_FIELD_W-1:0]   run_start_uid;
		bit [UID_FIELD_W-1:0]   prev_uid;
		bit                     any_emitted;
		bit [COUNT_W-1:0]       sel_count;
		res_t                   expected_tokens[$];
		int                     fail_count;

		function new();
			cfg = '0;
			fail_count = 0;
			clear_run();
		endfunction

		function void clear_run();
			run_open = 1'b0;
			run_start_uid = '0;
			prev_uid = '0;
			any_emitted = 1'b0;
			sel_count = '0;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FLAG_MODE:    cfg.flag_mode = data[MODE_W-1:0];
				CFG_CHANGED_ONLY: cfg.changed_only = data[0];
				CFG_INVERT_SENSE: cfg.invert_sense = data[0];
				default: ;
			endcase
		endfunction

		function void note_request(rec_t r);
			res_t want;
			logic sel;
			logic lb;
			logic sb;
			sel = 1'b0;
			want = '0;
			if (r.active) begin
				if (cfg.flag_mode <= MODE_REPLIED) begin
					lb = r.local_flags[cfg.flag_mode];
					sb = r.server_flags[cfg.flag_mode];
					sel = (lb != sb) && (lb ^ cfg.invert_sense);
				end else if (cfg.flag_mode == MODE_TAGGED) begin
					sel = r.tagged_req;
				end else if (cfg.flag_mode == MODE_TRASH) begin
					sel = r.local_flags[0] && !r.purge;
				end
			end
			if (cfg.changed_only && !r.changed_mark)
				sel = 1'b0;
			if (sel) begin
				if (sel_count != COUNT_MAX)
					sel_count++;
				if (!run_open) begin
					run_open = 1'b1;
					run_start_uid = r.uid;
					want.token_kind = any_emitted ? KIND_COMMA : KIND_FIRST;
					want.token_uid = r.uid;
					any_emitted = 1'b1;
				end else if (r.is_last) begin
					want.token_kind = KIND_COLON;
					want.token_uid = r.uid;
				end
			end else if (run_open && (r.active || r.is_last)) begin
				if (prev_uid > run_start_uid) begin
					want.token_kind = KIND_COLON;
					want.token_uid = prev_uid;
				end
				run_open = 1'b0;
			end
			want.match_count = sel_count;
			want.set_done = r.is_last;
			expected_tokens.push_back(want);
			prev_uid = r.uid;
			if (r.is_last)
				clear_run();
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d uid %0d",
					$time, got.token_kind, got.token_uid);
				fail_count++;
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$display("%0t: token_kind expected %0d actual %0d",
					$time, want.token_kind, got.token_kind);
				fail_count++;
			end
			if (got.token_uid !== want.token_uid) begin
				$display("%0t: token_uid expected %0d actual %0d",
					$time, want.token_uid, got.token_uid);
				fail_count++;
			end
			if (got.match_count !== want.match_count) begin
				$display("%0t: match_count expected %0d actual %0d",
					$time, want.match_count, got.match_count);
				fail_count++;
			end
			if (got.set_done !== want.set_done) begin
				$display("%0t: set_done expected %0d actual %0d",
					$time, want.set_done, got.set_done);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_FLAG_MODE;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    active = 1'b0;
	logic [4:0]              local_flags = '0;
	logic [4:0]              server_flags = '0;
	logic                    tagged_req = 1'b0;
	logic                    purge = 1'b0;
	logic                    changed_mark = 1'b0;
	logic [UID_FIELD_W-1:0]  uid = '0;
	logic                    is_last = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              token_kind;
	logic [UID_FIELD_W-1:0]  token_uid;
	logic [COUNT_W-1:0]      match_count;
	logic                    set_done;

	uid_set_scoreboard sb = new();
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit long_hold = 1'b0;
	int cycles = 0;

	flag_change_uid_set_builder dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic rec_t make_request(logic act, logic [4:0] loc, logic [4:0] srv,
		logic tag, logic prg, logic chg, logic [UID_FIELD_W-1:0] id, logic last);
		rec_t r;
		r.active = act;
		r.local_flags = loc;
		r.server_flags = srv;
		r.tagged_req = tag;
		r.purge = prg;
		r.changed_mark = chg;
		r.uid = id;
		r.is_last = last;
		return r;
	endfunction

	task automatic send_request(input rec_t r);
		int gap;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		active <= r.active;
		local_flags <= r.local_flags;
		server_flags <= r.server_flags;
		tagged_req <= r.tagged_req;
		purge <= r.purge;
		changed_mark <= r.changed_mark;
		uid <= r.uid;
		is_last <= r.is_last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic [MODE_W-1:0] mode, input logic chg,
		input logic inv);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0] vals [3];
		logic [CFG_DATA_W-1:0] pad;
		pad = CFG_DATA_W'($urandom_range(0, 7));
		idx = '{CFG_FLAG_MODE, CFG_CHANGED_ONLY, CFG_INVERT_SENSE};
		vals = '{mode, {pad[2:1], chg}, {pad[1:0], inv}};
		cfg_we <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.note_config(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_set(input int len);
		rec_t r;
		int seg;
		logic [UID_FIELD_W-1:0] next_uid;
		case ($urandom_range(0, 3))
			0: next_uid = '0;
			1: next_uid = 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: next_uid = $urandom;
		endcase
		seg = 0;
		r = '0;
		for (int i = 0; i < len; i++) begin
			if (seg == 0) begin
				seg = $urandom_range(1, 5);
				r.local_flags = 5'($urandom_range(0, 31));
				r.server_flags = 5'($urandom_range(0, 31));
				r.tagged_req = 1'($urandom_range(0, 1));
				r.purge = 1'($urandom_range(0, 1));
				r.changed_mark = $urandom_range(0, 3) != 0;
			end
			seg--;
			r.active = $urandom_range(0, 7) != 0;
			r.uid = next_uid;
			r.is_last = (i == len - 1);
			send_request(r);
			case ($urandom_range(0, 15))
				0: ;
				1: next_uid = next_uid + $urandom_range(2, 100);
				2: next_uid = $urandom;
				default: next_uid = next_uid + 1;
			endcase
		end
	endtask

	initial begin
		int count;
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: deleted mode, no invert, changed not required
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd1, 1'b0));
		send_request(make_request(1'b0, 5'h1f, 5'h00, 1'b1, 1'b0, 1'b1, 32'd2, 1'b0));
		send_request(make_request(1'b1, 5'h00, 5'h00, 1'b0, 1'b0, 1'b0, 32'd3, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b1, 1'b0, 32'd5, 1'b0));
		send_request(make_request(1'b1, 5'h00, 5'h01, 1'b0, 1'b0, 1'b0, 32'd6, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd7, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd8, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd9, 1'b1));
		// run open when an inactive last record arrives
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFE,
			1'b0));
		send_request(make_request(1'b0, 5'h00, 5'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
			1'b1));
		send_request(make_request(1'b1, 5'h1f, 5'h1e, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0,
			1'b0));
		send_request(make_request(1'b0, 5'h00, 5'h1f, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
			1'b0));
		send_request(make_request(1'b0, 5'h00, 5'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
			1'b1));
		send_request(make_request(1'b1, 5'h1f, 5'h1e, 1'b1, 1'b1, 1'b1, 32'hAAAA_AAAA,
			1'b1));
		send_request(make_request(1'b1, 5'h00, 5'h1f, 1'b0, 1'b0, 1'b0, 32'h5555_5555,
			1'b1));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd10, 1'b0));
		send_request(make_request(1'b0, 5'h00, 5'h00, 1'b0, 1'b0, 1'b0, 32'd11, 1'b0));
		send_request(make_request(1'b1, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd12, 1'b0));
		send_request(make_request(1'b0, 5'h01, 5'h00, 1'b0, 1'b0, 1'b0, 32'd13, 1'b1));
		wait_idle();

		for (int p = 0; p < 16; p++) begin
			apply_config(p[2:0], p[3], p[2] ^ p[3]);
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			if (p == 2) begin
				send_idle = 1'b0;
				long_hold = 1'b1;
			end
			count = 0;
			while (count < 74) begin
				len = $urandom_range(1, 12);
				random_set(len);
				count += len;
			end
			wait_idle();
		end

		if (sb.fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				hold = 60;
				long_hold = 1'b0;
			end else begin
				hold = recv_idle ? $urandom_range(0, 6) : 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result({token_kind, token_uid, match_count, set_done});
		end
	end

endmodule

>>> files.f
design/fcub_pkg.sv
design/fcub_select.sv
design/fcub_run.sv
design/fcub_outbuf.sv
design/flag_change_uid_set_builder.sv
sim/tb_top.sv
